@@ src/dual_crc_name_hash_matcher_core_defines.svh @@
// assertion macros for the dual crc name hash matcher
`ifndef DUAL_CRC_NAME_HASH_MATCHER_CORE_DEFINES_SVH
`define DUAL_CRC_NAME_HASH_MATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DCHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DCHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DCHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DCHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/dchm_pkg.sv @@
`timescale 1ns / 1ps
package dchm_pkg;

	localparam logic [31:0] POLY32     = 32'h04C1_1DB7;
	localparam logic [15:0] POLY16     = 16'h1021;
	localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	typedef enum logic [0:0] {
		REG_TARGET_CRC32 = 1'b0,
		REG_TARGET_CRC16 = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} dchm_in_t;

	typedef struct packed {
		logic        match;
		logic        too_long;
		logic [31:0] crc32_value;
		logic [15:0] crc16_value;
	} dchm_out_t;

	// one byte handed from the front to the back
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] crc32_value;
		logic        too_long;
	} dchm_entry_t;

	typedef struct packed {
		logic walk;
		logic emit;
	} dchm_status_t;

	function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ POLY32) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h0};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ POLY16) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ src/dchm_front.sv @@
`timescale 1ns / 1ps
module dchm_front #(
	parameter int MAX_NAME_LEN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dchm_pkg::dchm_in_t   in_data,
	input  logic                 q_full,
	output logic                 q_push,
	output dchm_pkg::dchm_entry_t q_entry
);

	localparam int CW = $clog2(MAX_NAME_LEN + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NAME_LEN);

	logic [31:0]   crc_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [31:0]   crc_next;
	logic          full_now;

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;
	assign crc_next = dchm_pkg::crc32_feed(crc_q, in_data.data_byte);
	assign full_now = (cnt_q == MAX_CNT);

	assign q_entry.data_byte   = in_data.data_byte;
	assign q_entry.last        = in_data.last;
	assign q_entry.crc32_value = ~crc_next;
	assign q_entry.too_long    = ovf_q | full_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= dchm_pkg::CRC32_INIT;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (q_push) begin
			if (in_data.last) begin
				crc_q <= dchm_pkg::CRC32_INIT;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				crc_q <= crc_next;
				if (full_now) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ src/dchm_queue.sv @@
`timescale 1ns / 1ps
module dchm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dchm_pkg::dchm_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output dchm_pkg::dchm_entry_t pop_entry,
	output logic                  empty
);

	dchm_pkg::dchm_entry_t slot_q [dchm_pkg::QUEUE_DEPTH];
	logic [dchm_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [dchm_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [dchm_pkg::QUEUE_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full      = (count_q == dchm_pkg::QUEUE_CW'(dchm_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & ~empty;
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ src/dchm_back.sv @@
`timescale 1ns / 1ps
module dchm_back #(
	parameter int MAX_NAME_LEN = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  dchm_pkg::dchm_entry_t  q_entry,
	input  logic [31:0]            target_crc32,
	input  logic [15:0]            target_crc16,
	output logic                   out_valid,
	input  logic                   out_stall,
	output dchm_pkg::dchm_out_t    out_data,
	output dchm_pkg::dchm_status_t status
);

	localparam int CW = $clog2(MAX_NAME_LEN + 1);
	localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NAME_LEN);

	typedef enum logic [2:0] {
		ST_FILL = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

	back_state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] ptr_q;
	logic          rd_pend_q;
	logic          out_valid_q;
	logic [15:0]   crc16_q;
	logic [31:0]   crc32_q;
	logic          too_long_q;
	logic [7:0]    rd_data_q;
	dchm_pkg::dchm_out_t out_q;
	logic [7:0]    mem [MAX_NAME_LEN];

	logic          has_room;
	logic          wr_en;
	logic [CW-1:0] cnt_after;
	logic          issue;
	logic          out_free;
	logic          fire;

	assign q_pop     = (state_q == ST_FILL) & ~q_empty;
	assign has_room  = (cnt_q < MAX_CNT);
	assign wr_en     = q_pop & has_room;
	assign cnt_after = has_room ? cnt_q + 1'b1 : cnt_q;
	assign issue     = (state_q == ST_WALK) & (rem_q != '0);
	assign out_free  = ~out_valid_q | ~out_stall;
	assign fire      = (state_q == ST_EMIT) & out_free;

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign status.walk = (state_q == ST_WALK);
	assign status.emit = (state_q == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			rem_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					if (q_pop) begin
						if (q_entry.last) begin
							cnt_q   <= '0;
							rem_q   <= cnt_after;
							state_q <= ST_WALK;
						end else begin
							cnt_q <= cnt_after;
						end
					end
				end
				ST_WALK: begin
					if (issue) begin
						rem_q <= rem_q - 1'b1;
					end else if (!rd_pend_q) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) begin
			ptr_q      <= AW'(cnt_after - 1'b1);
			crc16_q    <= dchm_pkg::CRC16_INIT;
			crc32_q    <= q_entry.crc32_value;
			too_long_q <= q_entry.too_long;
		end else begin
			if (issue) begin
				ptr_q <= ptr_q - 1'b1;
			end
			if (rd_pend_q) begin
				crc16_q <= dchm_pkg::crc16_feed(crc16_q, rd_data_q);
			end
		end
		if (fire) begin
			out_q.crc32_value <= crc32_q;
			out_q.crc16_value <= ~crc16_q;
			out_q.too_long    <= too_long_q;
			out_q.match       <= ~too_long_q & (crc32_q == target_crc32)
				& (~crc16_q == target_crc16);
		end
	end

	// name buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= q_entry.data_byte;
		end
		if (issue) begin
			rd_data_q <= mem[ptr_q];
		end
	end

endmodule

@@ src/dual_crc_name_hash_matcher_core.sv @@
`timescale 1ns / 1ps
// name hash matcher: takes a candidate name one byte per request (last marks the final
// byte), hashes it forward with a non-reflected crc-32 (poly 04c11db7, init all ones,
// inverted out) and backward over the first MAX_NAME_LEN stored bytes with a crc-16
// (poly 1021, init ffff, inverted out), and delivers one result per name with both hashes,
// too_long, and match (both hashes equal the targets and the name fit). the front takes a
// byte every cycle while its 4-entry queue has room; the back stores one byte per cycle
// while filling, then on the last byte walks the buffer backward through its single read
// port at one byte per cycle and hands the result off; it takes no new byte from the queue
// until that hand-off is done, so the queue absorbs bytes meanwhile. no clearing pass
// after reset. targets live at byte address 0 (crc-32) and 4 (crc-16, low 16 bits)
`include "dual_crc_name_hash_matcher_core_defines.svh"
module dual_crc_name_hash_matcher_core #(
	parameter int MAX_NAME_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// byte requests
	input  logic                in_valid,
	output logic                in_stall,
	input  dchm_pkg::dchm_in_t  in_data,
	// results
	output logic                out_valid,
	input  logic                out_stall,
	output dchm_pkg::dchm_out_t out_data
);

	logic [31:0] target_crc32_q;
	logic [15:0] target_crc16_q;
	logic        cfg_wr;
	dchm_pkg::reg_index_t cfg_idx;

	logic                   q_push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_empty;
	dchm_pkg::dchm_entry_t  push_entry;
	dchm_pkg::dchm_entry_t  pop_entry;
	dchm_pkg::dchm_status_t back_status;

	// register file, word index from paddr bit 2
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = dchm_pkg::reg_index_t'(paddr[2]);

	always_comb begin
		unique case (cfg_idx)
			dchm_pkg::REG_TARGET_CRC32: prdata = target_crc32_q;
			dchm_pkg::REG_TARGET_CRC16: prdata = {16'h0, target_crc16_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_crc32_q <= '0;
			target_crc16_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				dchm_pkg::REG_TARGET_CRC32: target_crc32_q <= pwdata;
				dchm_pkg::REG_TARGET_CRC16: target_crc16_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// front: running crc-32, length count, overflow flag
	dchm_front #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// short queue decouples byte intake from the backward walk
	dchm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// back: name buffer, crc-16 walk, compare and result register
	dchm_back #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_entry      (pop_entry),
		.target_crc32 (target_crc32_q),
		.target_crc16 (target_crc16_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.status       (back_status)
	);

	// a name that overflowed never matches
	`DCHM_ASSERT_NOW(a_match_not_long, clk, arst_n, out_valid, !(out_data.match && out_data.too_long), "match with too_long")
	// a new result only comes out of the hand-off step
	`DCHM_ASSERT_NOW(a_out_from_emit, clk, arst_n, $rose(out_valid), $past(back_status.emit), "result without hand-off")
	// the walk and the hand-off never overlap
	`DCHM_ASSERT_NOW(a_walk_emit_excl, clk, arst_n, back_status.walk, !back_status.emit, "walk and hand-off together")
	// the hand-off leaves as soon as the result register is free
	`DCHM_ASSERT_NEXT(a_emit_leaves, clk, arst_n, back_status.emit && (!out_valid || !out_stall), !back_status.emit && out_valid, "hand-off stuck")

endmodule
